### hw/rtl/ipbl_pkg.sv
package ipbl_pkg;

	localparam int TABLE_ENTRIES_DEF = 1024;

	localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [5:0]  COUNT_MAX      = 6'd63;

	// Byte positions within the frame, counted from zero.
	localparam logic [5:0] POS_ETYPE_HI = 6'd12;
	localparam logic [5:0] POS_ETYPE_LO = 6'd13;
	localparam logic [5:0] POS_PROTO    = 6'd23;
	localparam logic [5:0] POS_SRC_FIRST = 6'd26;
	localparam logic [5:0] POS_SRC_LAST  = 6'd29;
	localparam logic [5:0] POS_PORT_HI  = 6'd36;
	localparam logic [5:0] POS_PORT_LO  = 6'd37;

	// Minimum frame lengths.
	localparam logic [5:0] LEN_ETH  = 6'd14;
	localparam logic [5:0] LEN_IPV4 = 6'd34;
	localparam logic [5:0] LEN_UDP  = 6'd42;
	localparam logic [5:0] LEN_TCP  = 6'd54;

	typedef struct packed {
		logic        verdict;
		logic        event_valid;
		logic [31:0] source_address;
		logic [15:0] dest_port;
		logic        protocol;
		logic        write_status;
	} result_t;

	typedef struct packed {
		logic [5:0]  len;
		logic [15:0] ether_type;
		logic [7:0]  protocol;
		logic [31:0] source;
		logic [15:0] port;
		logic        blocked;
	} frame_t;

	typedef struct packed {
		logic take;
		logic clear;
		logic set_blk;
		logic blk;
	} frame_ctl_t;

	typedef struct packed {
		logic        start;
		logic        insert;
		logic [31:0] key;
		logic        blocked;
	} tbl_req_t;

	typedef struct packed {
		logic ready;
		logic done;
		logic blocked;
		logic full;
	} tbl_rsp_t;

	typedef struct packed {
		logic        valid;
		logic        blocked;
		logic [31:0] key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic result_t frame_verdict(input frame_t f);
		result_t r;
		r = '0;
		if (f.len < LEN_ETH) begin
			r.verdict = 1'b1;
		end else if (f.ether_type != IPV4_ETHERTYPE) begin
			r.verdict = 1'b0;
		end else if (f.len < LEN_IPV4 || f.blocked) begin
			r.verdict = 1'b1;
		end else if (f.protocol == PROTO_TCP && f.len < LEN_TCP) begin
			r.verdict = 1'b1;
		end else if (f.protocol == PROTO_UDP && f.len < LEN_UDP) begin
			r.verdict = 1'b1;
		end else begin
			r.event_valid    = 1'b1;
			r.source_address = f.source;
			if (f.protocol == PROTO_TCP) begin
				r.dest_port = f.port;
			end else if (f.protocol == PROTO_UDP) begin
				r.dest_port = f.port;
				r.protocol  = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

### hw/rtl/ipbl_if.sv
interface ipbl_req_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [7:0]         data_byte;
	logic               last;
	logic [31:0]        entry_address;
	logic signed [31:0] entry_value;

	modport source(output valid, kind, data_byte, last, entry_address, entry_value,
		input ready);
	modport sink(input valid, kind, data_byte, last, entry_address, entry_value,
		output ready);
endinterface

interface ipbl_rsp_if;
	logic        valid;
	logic        ready;
	logic        verdict;
	logic        event_valid;
	logic [31:0] source_address;
	logic [15:0] dest_port;
	logic        protocol;
	logic        write_status;

	modport source(output valid, verdict, event_valid, source_address, dest_port,
		protocol, write_status, input ready);
	modport sink(input valid, verdict, event_valid, source_address, dest_port,
		protocol, write_status, output ready);
endinterface

### hw/rtl/ipbl_ram.sv
module ipbl_ram #(
	parameter int WIDTH = ipbl_pkg::ENTRY_W,
	parameter int DEPTH = ipbl_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/ipbl_frame.sv
module ipbl_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipbl_pkg::frame_ctl_t  ctl,
	input  logic [7:0]            data_byte,
	output ipbl_pkg::frame_t      frm,
	output logic                  probe,
	output logic [31:0]           probe_key
);

	logic [5:0]  cnt_q;
	logic [15:0] ether_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [15:0] port_q;
	logic        blocked_q;

	// The source address is complete once its last byte is shifted in.
	assign probe     = ctl.take && (cnt_q == ipbl_pkg::POS_SRC_LAST);
	assign probe_key = {src_q[23:0], data_byte};

	assign frm = '{len: cnt_q, ether_type: ether_q, protocol: proto_q,
		source: src_q, port: port_q, blocked: blocked_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			ether_q   <= '0;
			proto_q   <= '0;
			src_q     <= '0;
			port_q    <= '0;
			blocked_q <= 1'b0;
		end else if (ctl.clear) begin
			cnt_q     <= '0;
			ether_q   <= '0;
			proto_q   <= '0;
			src_q     <= '0;
			port_q    <= '0;
			blocked_q <= 1'b0;
		end else begin
			if (ctl.take) begin
				if (cnt_q == ipbl_pkg::POS_ETYPE_HI || cnt_q == ipbl_pkg::POS_ETYPE_LO) begin
					ether_q <= {ether_q[7:0], data_byte};
				end else if (cnt_q == ipbl_pkg::POS_PROTO) begin
					proto_q <= data_byte;
				end else if (cnt_q >= ipbl_pkg::POS_SRC_FIRST
						&& cnt_q <= ipbl_pkg::POS_SRC_LAST) begin
					src_q <= {src_q[23:0], data_byte};
				end else if (cnt_q == ipbl_pkg::POS_PORT_HI
						|| cnt_q == ipbl_pkg::POS_PORT_LO) begin
					port_q <= {port_q[7:0], data_byte};
				end
				if (cnt_q != ipbl_pkg::COUNT_MAX) begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
			if (ctl.set_blk) begin
				blocked_q <= ctl.blk;
			end
		end
	end

endmodule

### hw/rtl/ipbl_table.sv
module ipbl_table #(
	parameter int ENTRIES = ipbl_pkg::TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ipbl_pkg::tbl_req_t req,
	output ipbl_pkg::tbl_rsp_t rsp
);

	localparam int IW = $clog2(ENTRIES);

	typedef enum logic [1:0] {
		T_CLEAR,
		T_IDLE,
		T_CHECK
	} tstate_t;

	tstate_t          state_q;
	logic [IW-1:0]    idx_q;
	logic [IW-1:0]    cnt_q;
	logic [IW-1:0]    clr_q;
	logic [31:0]      key_q;
	logic             ins_q;
	logic             blk_q;

	logic                          we;
	logic [IW-1:0]                 waddr;
	logic [ipbl_pkg::ENTRY_W-1:0]  wdata;
	logic [IW-1:0]                 raddr;
	logic [ipbl_pkg::ENTRY_W-1:0]  rdata;
	ipbl_pkg::entry_t              ent;
	logic                          hit;
	logic                          empty;
	logic                          at_end;
	logic [IW-1:0]                 nxt;

	// XOR-fold of the key onto the index, brought below ENTRIES by one subtract.
	function automatic logic [IW-1:0] slot_hash(input logic [31:0] k);
		logic [IW-1:0] h;
		logic [IW:0]   w;
		h = '0;
		for (int i = 0; i < 32; i++) begin
			h[i % IW] = h[i % IW] ^ k[i];
		end
		w = {1'b0, h};
		if (w >= (IW+1)'(ENTRIES)) begin
			w = w - (IW+1)'(ENTRIES);
		end
		return w[IW-1:0];
	endfunction

	assign ent    = ipbl_pkg::entry_t'(rdata);
	assign hit    = ent.valid && (ent.key == key_q);
	assign empty  = !ent.valid;
	assign at_end = (cnt_q == IW'(ENTRIES - 1));
	assign nxt    = (idx_q == IW'(ENTRIES - 1)) ? '0 : idx_q + 1'b1;
	assign raddr  = (state_q == T_CHECK) ? nxt : slot_hash(req.key);

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = '0;
		rsp   = '0;
		rsp.ready = (state_q == T_IDLE);
		unique case (state_q)
			T_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			T_CHECK: begin
				rsp.done    = hit || empty || at_end;
				rsp.blocked = !ins_q && hit && ent.blocked;
				rsp.full    = ins_q && !hit && !empty;
				if (ins_q && (hit || empty)) begin
					we    = 1'b1;
					wdata = ipbl_pkg::entry_t'{valid: 1'b1, blocked: blk_q, key: key_q};
				end
			end
			T_IDLE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_CLEAR;
			idx_q   <= '0;
			cnt_q   <= '0;
			clr_q   <= '0;
			key_q   <= '0;
			ins_q   <= 1'b0;
			blk_q   <= 1'b0;
		end else begin
			unique case (state_q)
				T_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(ENTRIES - 1)) begin
						state_q <= T_IDLE;
					end
				end
				T_IDLE: begin
					if (req.start) begin
						idx_q   <= slot_hash(req.key);
						cnt_q   <= '0;
						key_q   <= req.key;
						ins_q   <= req.insert;
						blk_q   <= req.blocked;
						state_q <= T_CHECK;
					end
				end
				T_CHECK: begin
					if (hit || empty || at_end) begin
						state_q <= T_IDLE;
					end else begin
						idx_q <= nxt;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	ipbl_ram #(
		.WIDTH(ipbl_pkg::ENTRY_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

endmodule

### hw/rtl/ipv4_blacklist_packet_filter_unit.sv
// A frame byte that is neither the last nor the last source address byte leaves the block
// idle and ready for the next word. The verdict word of a last byte is registered in a
// pending register and moves to the output register once that register is free; no new
// word is taken until it has moved. The last source address byte starts a hashed probe of
// the blacklist memory, one entry per cycle on the single read port; a blacklist write
// probes the same way; its status word passes the pending register to the output register.
// After reset a clearing pass over all TABLE_ENTRIES entries runs before any word is taken.
module ipv4_blacklist_packet_filter_unit #(
	parameter int TABLE_ENTRIES = ipbl_pkg::TABLE_ENTRIES_DEF
) (
	input logic      clk,
	input logic      arst_n,
	ipbl_req_if.sink   req,
	ipbl_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE,
		S_WRITE,
		S_FINISH,
		S_EMIT
	} state_t;

	state_t               state_q;
	logic                 last_q;
	ipbl_pkg::result_t    pend_q;
	ipbl_pkg::result_t    out_q;
	logic                 ov_q;

	logic                 acc;
	logic                 slot_free;
	ipbl_pkg::frame_ctl_t frm_ctl;
	ipbl_pkg::frame_t     frm;
	logic                 frm_probe;
	logic [31:0]          probe_key;
	ipbl_pkg::tbl_req_t   tbl_req;
	ipbl_pkg::tbl_rsp_t   tbl_rsp;

	assign req.ready = (state_q == S_IDLE) && tbl_rsp.ready;
	assign acc       = req.valid && req.ready;
	assign slot_free = !ov_q || rsp.ready;

	assign frm_ctl.take    = acc && !req.kind;
	assign frm_ctl.clear   = (state_q == S_FINISH);
	assign frm_ctl.set_blk = (state_q == S_PROBE) && tbl_rsp.done;
	assign frm_ctl.blk     = tbl_rsp.blocked;

	assign tbl_req.start   = acc && (req.kind || frm_probe);
	assign tbl_req.insert  = req.kind;
	assign tbl_req.key     = req.kind ? req.entry_address : probe_key;
	assign tbl_req.blocked = (req.entry_value == 32'sd1);

	assign rsp.valid          = ov_q;
	assign rsp.verdict        = out_q.verdict;
	assign rsp.event_valid    = out_q.event_valid;
	assign rsp.source_address = out_q.source_address;
	assign rsp.dest_port      = out_q.dest_port;
	assign rsp.protocol       = out_q.protocol;
	assign rsp.write_status   = out_q.write_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
			pend_q  <= '0;
			out_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (state_q == S_EMIT && slot_free) begin
				ov_q  <= 1'b1;
				out_q <= pend_q;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (req.kind) begin
							state_q <= S_WRITE;
						end else if (frm_probe) begin
							last_q  <= req.last;
							state_q <= S_PROBE;
						end else if (req.last) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_PROBE: begin
					if (tbl_rsp.done) begin
						state_q <= last_q ? S_FINISH : S_IDLE;
					end
				end
				S_WRITE: begin
					if (tbl_rsp.done) begin
						pend_q  <= '{write_status: tbl_rsp.full, default: '0};
						state_q <= S_EMIT;
					end
				end
				S_FINISH: begin
					pend_q  <= ipbl_pkg::frame_verdict(frm);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ipbl_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (frm_ctl),
		.data_byte(req.data_byte),
		.frm      (frm),
		.probe    (frm_probe),
		.probe_key(probe_key)
	);

	ipbl_table #(
		.ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (tbl_req),
		.rsp   (tbl_rsp)
	);

	a_event_passes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.event_valid |-> !rsp.verdict && !rsp.write_status)
		else $error("event word carries a drop verdict or write status");

	a_probe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_req.start |-> tbl_rsp.ready)
		else $error("table probe started while the table was busy");

	a_last_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !req.kind && req.last |=> state_q != S_IDLE)
		else $error("last byte accepted without a verdict in progress");

	a_write_word: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRITE && tbl_rsp.done |=> state_q == S_EMIT && !pend_q.verdict
			&& !pend_q.event_valid)
		else $error("blacklist write result not queued correctly");

endmodule

### bench/tb_ipv4_blacklist_packet_filter_unit.sv
`timescale 1ns / 100ps

module tb_ipv4_blacklist_packet_filter_unit;

	localparam int LIST_DEPTH     = ipbl_pkg::TABLE_ENTRIES_DEF;
	localparam int WATCHDOG_LIMIT = 8 * LIST_DEPTH;
	localparam int TAIL_CYCLES    = 32;
	localparam int HOLD_CYCLES    = 300;
	localparam int REPORT_LIMIT   = 10;
	localparam int RANDOM_WORDS   = 120;
	localparam int NUM_ROWS       = 23;

	typedef enum logic {WORD_BYTE = 1'b0, WORD_ENTRY = 1'b1} word_kind_t;

	localparam logic [15:0] IPV4_ETHERTYPE = ipbl_pkg::IPV4_ETHERTYPE;
	localparam logic [7:0]  PROTO_TCP      = ipbl_pkg::PROTO_TCP;
	localparam logic [7:0]  PROTO_UDP      = ipbl_pkg::PROTO_UDP;

	localparam logic VERDICT_DROP  = 1'b1;
	localparam logic PROTO_OUT_UDP = 1'b1;
	localparam logic WRITE_FULL    = 1'b1;

	localparam logic        ROW_FRAME  = 1'b0;
	localparam logic        ROW_ENTRY  = 1'b1;
	localparam logic [7:0]  NO_INSERT  = 8'hFF;
	localparam logic [7:0]  PROTO_ICMP = 8'd1;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
	localparam logic [15:0] ETYPE_NONE = 16'h0000;
	localparam logic [31:0] HOST_A     = 32'hC0A8_0001;
	localparam logic [31:0] HOST_B     = 32'hFFFF_FFFF;
	localparam logic [31:0] HOST_C     = 32'h0A0A_0A0A;
	localparam logic [31:0] HOST_D     = 32'h0A00_0001;

	localparam ipbl_pkg::result_t RES_QUIET = '0;
	localparam ipbl_pkg::result_t RES_DROP  = '{verdict: VERDICT_DROP, default: '0};

	// One directed case: a blacklist write, or a frame built from its header fields.
	// A frame may carry a write of its own source, inserted before byte ins_at.
	typedef struct packed {
		logic              is_entry;
		logic [7:0]        len;
		logic [15:0]       etype;
		logic [7:0]        proto;
		logic [31:0]       src;
		logic [15:0]       port;
		logic [31:0]       val;
		logic [7:0]        ins_at;
		logic              typed;
		ipbl_pkg::result_t want;
	} case_row_t;

	case_row_t case_rows [0:NUM_ROWS-1] = '{
		'{ROW_ENTRY, 8'd0,   ETYPE_NONE,     8'd0,      HOST_A, 16'h0000, 32'd1,
			NO_INSERT, 1'b1, RES_QUIET},
		'{ROW_FRAME, 8'd1,   IPV4_ETHERTYPE, PROTO_TCP, HOST_A, 16'h0000, 32'd0,
			NO_INSERT, 1'b1, RES_DROP},
		'{ROW_FRAME, 8'd13,  IPV4_ETHERTYPE, PROTO_TCP, HOST_D, 16'h0050, 32'd0,
			NO_INSERT, 1'b1, RES_DROP},
		'{ROW_FRAME, 8'd14,  ETYPE_IPV6,     PROTO_TCP, HOST_D, 16'h0050, 32'd0,
			NO_INSERT, 1'b1, RES_QUIET},
		'{ROW_FRAME, 8'd14,  IPV4_ETHERTYPE, PROTO_TCP, HOST_D, 16'h0050, 32'd0,
			NO_INSERT, 1'b1, RES_DROP},
		'{ROW_FRAME, 8'd33,  IPV4_ETHERTYPE, PROTO_TCP, HOST_D, 16'h0050, 32'd0,
			NO_INSERT, 1'b1, RES_DROP},
		'{ROW_FRAME, 8'd34,  IPV4_ETHERTYPE, PROTO_ICMP, HOST_D, 16'h1234, 32'd0,
			NO_INSERT, 1'b0, RES_QUIET},
		'{ROW_FRAME, 8'd53,  IPV4_ETHERTYPE, PROTO_TCP, 32'h0,  16'h0050, 32'd0,
			NO_INSERT, 1'b1, RES_DROP},
		'{ROW_FRAME, 8'd54,  IPV4_ETHERTYPE, PROTO_TCP, HOST_B, 16'hFFFF, 32'd0,
			NO_INSERT, 1'b0, RES_QUIET},
		'{ROW_FRAME, 8'd41,  IPV4_ETHERTYPE, PROTO_UDP, HOST_D, 16'h0035, 32'd0,
			NO_INSERT, 1'b1, RES_DROP},
		'{ROW_FRAME, 8'd42,  IPV4_ETHERTYPE, PROTO_UDP, 32'h0,  16'h0000, 32'd0,
			NO_INSERT, 1'b0, RES_QUIET},
		'{ROW_FRAME, 8'd60,  IPV4_ETHERTYPE, PROTO_TCP, HOST_A, 16'h0050, 32'd0,
			NO_INSERT, 1'b1, RES_DROP},
		'{ROW_ENTRY, 8'd0,   ETYPE_NONE,     8'd0,      HOST_A, 16'h0000, 32'd0,
			NO_INSERT, 1'b1, RES_QUIET},
		'{ROW_FRAME, 8'd60,  IPV4_ETHERTYPE, PROTO_UDP, HOST_A, 16'h04D2, 32'd0,
			NO_INSERT, 1'b0, RES_QUIET},
		'{ROW_ENTRY, 8'd0,   ETYPE_NONE,     8'd0,      HOST_B, 16'h0000, 32'h8000_0000,
			NO_INSERT, 1'b1, RES_QUIET},
		'{ROW_ENTRY, 8'd0,   ETYPE_NONE,     8'd0,      HOST_B, 16'h0000, 32'h7FFF_FFFF,
			NO_INSERT, 1'b1, RES_QUIET},
		'{ROW_FRAME, 8'd63,  IPV4_ETHERTYPE, PROTO_TCP, HOST_A, 16'h01BB, 32'd1,
			8'd31, 1'b0, RES_QUIET},
		'{ROW_FRAME, 8'd63,  IPV4_ETHERTYPE, PROTO_TCP, HOST_A, 16'h01BB, 32'd0,
			8'd31, 1'b1, RES_DROP},
		'{ROW_FRAME, 8'd100, IPV4_ETHERTYPE, PROTO_UDP, HOST_D, 16'h1F90, 32'd0,
			NO_INSERT, 1'b0, RES_QUIET},
		'{ROW_ENTRY, 8'd0,   ETYPE_NONE,     8'd0,      HOST_B, 16'h0000, 32'hFFFF_FFFF,
			NO_INSERT, 1'b1, RES_QUIET},
		'{ROW_FRAME, 8'd64,  ETYPE_NONE,     PROTO_UDP, HOST_D, 16'h0035, 32'd0,
			NO_INSERT, 1'b1, RES_QUIET},
		'{ROW_FRAME, 8'd54,  IPV4_ETHERTYPE, PROTO_TCP, HOST_C, 16'h0016, 32'd1,
			8'd20, 1'b1, RES_DROP},
		'{ROW_FRAME, 8'd54,  IPV4_ETHERTYPE, PROTO_TCP, HOST_B, 16'h0017, 32'd0,
			NO_INSERT, 1'b0, RES_QUIET}
	};

	logic clk = 1'b0;
	logic arst_n;

	ipbl_req_if req_ch ();
	ipbl_rsp_if rsp_ch ();

	ipv4_blacklist_packet_filter_unit #(
		.TABLE_ENTRIES(LIST_DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Frame capture state and blacklist contents as the block should hold them.
	logic [5:0]  fr_count   = '0;
	logic [15:0] fr_etype   = '0;
	logic [7:0]  fr_proto   = '0;
	logic [31:0] fr_src     = '0;
	logic [15:0] fr_port    = '0;
	logic        fr_blocked = 1'b0;
	bit          deny_list [bit [31:0]];

	ipbl_pkg::result_t pending_verdicts [$];
	int      mismatch_count = 0;
	int      words_sent     = 0;
	int      send_idle_pct  = 20;
	int      recv_idle_pct  = 61;
	int      hold_requests  = 0;
	logic    typed_armed    = 1'b0;
	ipbl_pkg::result_t typed_want = '0;
	logic [31:0] src_pool [16];

	function automatic bit filter_step(input logic kind, input logic [7:0] b, input logic last,
			input logic [31:0] addr, input logic signed [31:0] val,
			output ipbl_pkg::result_t res);
		logic [5:0] pos;
		logic [5:0] len;
		res = '0;
		if (kind == WORD_ENTRY) begin
			if (deny_list.exists(addr) || deny_list.num() < LIST_DEPTH)
				deny_list[addr] = (val == 1);
			else
				res.write_status = WRITE_FULL;
			return 1'b1;
		end
		pos = fr_count;
		if (pos == ipbl_pkg::POS_ETYPE_HI || pos == ipbl_pkg::POS_ETYPE_LO)
			fr_etype = {fr_etype[7:0], b};
		else if (pos == ipbl_pkg::POS_PROTO)
			fr_proto = b;
		else if (pos >= ipbl_pkg::POS_SRC_FIRST && pos <= ipbl_pkg::POS_SRC_LAST)
			fr_src = {fr_src[23:0], b};
		else if (pos == ipbl_pkg::POS_PORT_HI || pos == ipbl_pkg::POS_PORT_LO)
			fr_port = {fr_port[7:0], b};
		// The blacklist is consulted once, as the last source byte arrives.
		if (pos == ipbl_pkg::POS_SRC_LAST)
			fr_blocked = deny_list.exists(fr_src) && deny_list[fr_src];
		if (fr_count != ipbl_pkg::COUNT_MAX)
			fr_count++;
		if (!last)
			return 1'b0;
		len = fr_count;
		if (len < ipbl_pkg::LEN_ETH) begin
			res.verdict = VERDICT_DROP;
		end else if (fr_etype != IPV4_ETHERTYPE) begin
			res = RES_QUIET;
		end else if (len < ipbl_pkg::LEN_IPV4 || fr_blocked) begin
			res.verdict = VERDICT_DROP;
		end else if (fr_proto == PROTO_TCP && len < ipbl_pkg::LEN_TCP) begin
			res.verdict = VERDICT_DROP;
		end else if (fr_proto == PROTO_UDP && len < ipbl_pkg::LEN_UDP) begin
			res.verdict = VERDICT_DROP;
		end else begin
			res.event_valid    = 1'b1;
			res.source_address = fr_src;
			if (fr_proto == PROTO_TCP) begin
				res.dest_port = fr_port;
			end else if (fr_proto == PROTO_UDP) begin
				res.dest_port = fr_port;
				res.protocol  = PROTO_OUT_UDP;
			end
		end
		fr_count   = '0;
		fr_etype   = '0;
		fr_proto   = '0;
		fr_src     = '0;
		fr_port    = '0;
		fr_blocked = 1'b0;
		return 1'b1;
	endfunction

	function automatic void flag_mismatch(input string what, input ipbl_pkg::result_t want,
			input ipbl_pkg::result_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("%0t %s: expected verdict %0d event %0d src %h port %h proto %0d status %0d",
				$time, what, want.verdict, want.event_valid, want.source_address,
				want.dest_port, want.protocol, want.write_status);
			$display("%0t %s: actual   verdict %0d event %0d src %h port %h proto %0d status %0d",
				$time, what, got.verdict, got.event_valid, got.source_address,
				got.dest_port, got.protocol, got.write_status);
		end
	endfunction

	always @(posedge clk) begin
		ipbl_pkg::result_t got;
		ipbl_pkg::result_t pred;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.verdict, rsp_ch.event_valid, rsp_ch.source_address,
					rsp_ch.dest_port, rsp_ch.protocol, rsp_ch.write_status};
				if (pending_verdicts.size() == 0)
					flag_mismatch("unexpected word", RES_QUIET, got);
				else if (got !== pending_verdicts[0])
					flag_mismatch("wrong word", pending_verdicts.pop_front(), got);
				else
					void'(pending_verdicts.pop_front());
			end
			if (req_ch.valid && req_ch.ready) begin
				if (filter_step(req_ch.kind, req_ch.data_byte, req_ch.last,
						req_ch.entry_address, req_ch.entry_value, pred)) begin
					if (typed_armed) begin
						pending_verdicts.push_back(typed_want);
						typed_armed = 1'b0;
					end else begin
						pending_verdicts.push_back(pred);
					end
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	task automatic send_word(input logic kind, input logic [7:0] b, input logic last,
			input logic [31:0] addr, input logic signed [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.kind          <= kind;
		req_ch.data_byte     <= b;
		req_ch.last          <= last;
		req_ch.entry_address <= addr;
		req_ch.entry_value   <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_entry(input logic [31:0] addr, input logic signed [31:0] val,
			input logic last);
		send_word(WORD_ENTRY, 8'($urandom), last, addr, val);
	endtask

	task automatic send_frame(input int len, input logic [15:0] etype, input logic [7:0] proto,
			input logic [31:0] src, input logic [15:0] port, input int ins_at,
			input logic signed [31:0] ins_val, input logic typed,
			input ipbl_pkg::result_t want);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			// A write landing inside a frame always has last set; it must be ignored.
			if (i == ins_at)
				send_entry(src, ins_val, 1'b1);
			if (i == ipbl_pkg::POS_ETYPE_HI)
				b = etype[15:8];
			else if (i == ipbl_pkg::POS_ETYPE_LO)
				b = etype[7:0];
			else if (i == ipbl_pkg::POS_PROTO)
				b = proto;
			else if (i >= ipbl_pkg::POS_SRC_FIRST && i <= ipbl_pkg::POS_SRC_LAST)
				b = src[8 * (int'(ipbl_pkg::POS_SRC_LAST) - i) +: 8];
			else if (i == ipbl_pkg::POS_PORT_HI)
				b = port[15:8];
			else if (i == ipbl_pkg::POS_PORT_LO)
				b = port[7:0];
			else
				b = 8'($urandom);
			if (i == len - 1 && typed) begin
				typed_want  = want;
				typed_armed = 1'b1;
			end
			send_word(WORD_BYTE, b, i == len - 1, $urandom, $urandom);
		end
	endtask

	function automatic logic [31:0] pick_source();
		if ($urandom_range(99) < 75)
			return src_pool[$urandom_range(15)];
		return $urandom;
	endfunction

	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return 32'sd1;
		if (r < 55)
			return 32'sd0;
		if (r < 62)
			return 32'h8000_0000;
		if (r < 69)
			return 32'h7FFF_FFFF;
		if (r < 75)
			return -32'sd1;
		return $urandom;
	endfunction

	// Mostly well-formed IPv4 frames with random content, some short or foreign frames,
	// and now and then a blacklist write inside the frame.
	task automatic send_random_frame();
		int r;
		int len;
		int p;
		logic [15:0] etype;
		logic [7:0]  proto;
		r = $urandom_range(99);
		if (r < 8)
			len = $urandom_range(1, 13);
		else if (r < 18)
			len = $urandom_range(14, 33);
		else if (r < 93)
			len = $urandom_range(34, 63);
		else
			len = $urandom_range(64, 90);
		etype = ($urandom_range(99) < 85) ? IPV4_ETHERTYPE : 16'($urandom);
		p = $urandom_range(99);
		if (p < 40)
			proto = PROTO_TCP;
		else if (p < 80)
			proto = PROTO_UDP;
		else
			proto = 8'($urandom);
		send_frame(len, etype, proto, pick_source(), 16'($urandom),
			($urandom_range(99) < 25) ? $urandom_range(len - 1) : -1,
			pick_value(), 1'b0, RES_QUIET);
	endtask

	task automatic run_random(input int n);
		int target;
		target = words_sent + n;
		while (words_sent < target) begin
			if ($urandom_range(99) < 25)
				send_entry(pick_source(), pick_value(), 1'($urandom_range(1)));
			else
				send_random_frame();
		end
	endtask

	initial begin
		int ins;
		logic [31:0] fresh;
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.kind          = WORD_BYTE;
		req_ch.data_byte     = '0;
		req_ch.last          = 1'b0;
		req_ch.entry_address = '0;
		req_ch.entry_value   = '0;
		src_pool[0] = 32'h0000_0000;
		src_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 16; i++)
			src_pool[i] = $urandom;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (case_rows[n]) begin
			if (case_rows[n].is_entry == ROW_ENTRY) begin
				if (case_rows[n].typed) begin
					typed_want  = case_rows[n].want;
					typed_armed = 1'b1;
				end
				send_entry(case_rows[n].src, case_rows[n].val, 1'b0);
			end else begin
				ins = (case_rows[n].ins_at == NO_INSERT) ? -1 : int'(case_rows[n].ins_at);
				send_frame(int'(case_rows[n].len), case_rows[n].etype, case_rows[n].proto,
					case_rows[n].src, case_rows[n].port, ins, case_rows[n].val,
					case_rows[n].typed, case_rows[n].want);
			end
		end

		run_random(RANDOM_WORDS);
		send_idle_pct = 61;
		recv_idle_pct = 20;
		run_random(RANDOM_WORDS);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// Back-to-back writes against a stalled output fill the block up.
		hold_requests++;
		repeat (30)
			send_entry(pick_source(), pick_value(), 1'($urandom_range(1)));
		run_random(RANDOM_WORDS);

		// Fill the blacklist to the brim, then probe its behavior when full.
		while (deny_list.num() < LIST_DEPTH) begin
			do
				fresh = $urandom;
			while (deny_list.exists(fresh));
			send_entry(fresh, pick_value(), 1'($urandom_range(1)));
		end
		repeat (3) begin
			do
				fresh = $urandom;
			while (deny_list.exists(fresh));
			send_entry(fresh, 32'sd1, 1'b0);
		end
		send_entry(HOST_A, 32'sd1, 1'b0);
		send_frame(54, IPV4_ETHERTYPE, PROTO_TCP, HOST_A, 16'h0050, -1, 0, 1'b1, RES_DROP);
		send_entry(HOST_A, 32'sd0, 1'b1);
		send_frame(42, IPV4_ETHERTYPE, PROTO_UDP, HOST_A, 16'h0035, -1, 0, 1'b0, RES_QUIET);
		send_frame(54, IPV4_ETHERTYPE, PROTO_TCP, fresh, 16'h01BB, -1, 0, 1'b0, RES_QUIET);
		req_ch.valid <= 1'b0;

		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_verdicts.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
